// File: hdl/mxp_pkg.sv
// Shared types and constants for the minimum-XOR pair trie search unit.
package mxp_pkg;
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_S_RD,
		ST_S_WT,
		ST_S_DEC,
		ST_S_LEAF,
		ST_S_VAL,
		ST_S_SCORE,
		ST_I_RD,
		ST_I_WT,
		ST_I_DEC,
		ST_I_LEAF,
		ST_EMIT
	} mxp_state_t;

	typedef struct packed {
		logic start;
		logic s_step;
		logic val_read;
		logic score;
		logic i_step;
		logic leaf_write;
		logic count_inc;
	} mxp_cmd_t;

	typedef struct packed {
		logic word_last;
		logic item_last;
		logic set_full;
		logic have_items;
		logic levels_done;
		logic s_stop;
		logic i_stop;
	} mxp_status_t;
endpackage

// File: hdl/mxp_ctrl.sv
// Controller state machine sequencing search and insertion walks.
module mxp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 out_stall,
	output logic                 out_valid,
	input  mxp_pkg::mxp_status_t sts,
	output mxp_pkg::mxp_cmd_t    cmd
);
	import mxp_pkg::*;

	mxp_state_t state_q, state_nx;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				if (sts.set_full) state_nx = sts.word_last ? ST_EMIT : ST_IDLE;
				else if (sts.have_items) state_nx = ST_S_RD;
				else state_nx = ST_I_RD;
			end
			ST_S_RD: state_nx = sts.levels_done ? ST_S_LEAF : ST_S_WT;
			ST_S_WT: state_nx = ST_S_DEC;
			ST_S_DEC: state_nx = sts.s_stop ? ST_S_LEAF : ST_S_RD;
			ST_S_LEAF: state_nx = ST_S_VAL;
			ST_S_VAL: state_nx = ST_S_SCORE;
			ST_S_SCORE: state_nx = ST_I_RD;
			ST_I_RD: state_nx = sts.levels_done ? ST_I_LEAF : ST_I_WT;
			ST_I_WT: state_nx = ST_I_DEC;
			ST_I_DEC: state_nx = sts.i_stop ? (sts.item_last ? ST_EMIT : ST_IDLE) : ST_I_RD;
			ST_I_LEAF: state_nx = sts.item_last ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (!out_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// drive commands
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.start = in_valid;
			end
			ST_S_DEC: cmd.s_step = 1'b1;
			ST_S_VAL: cmd.val_read = 1'b1;
			ST_S_SCORE: cmd.score = 1'b1;
			ST_I_DEC: begin
				cmd.i_step = 1'b1;
				cmd.count_inc = sts.i_stop;
			end
			ST_I_LEAF: begin
				cmd.leaf_write = 1'b1;
				cmd.count_inc = 1'b1;
			end
			ST_EMIT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// File: hdl/mxp_dp.sv
// Datapath: node, leaf and value memories, walk registers and best pair.
module mxp_dp #(
	parameter int MAX_ITEMS    = 1024,
	parameter int MAX_KEY_BITS = 30,
	parameter int MAX_NODES    = 32768,
	parameter int VW = 30,
	parameter int KW = 5,
	parameter int IW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mxp_pkg::mxp_cmd_t    cmd,
	output mxp_pkg::mxp_status_t sts,
	input  logic [KW-1:0]        key_bits,
	input  logic [VW-1:0]        value,
	input  logic                 first_of_set,
	input  logic                 last_of_set,
	output logic                 pair_found,
	output logic [IW-1:0]        lower_index,
	output logic [IW-1:0]        higher_index,
	output logic [VW-1:0]        best_mask
);
	import mxp_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int LW  = $clog2(MAX_KEY_BITS + 1);
	localparam int BW  = $clog2(VW);

	// node memories, two children per node and a leaf item
	logic [NW-1:0] kid0_mem [MAX_NODES];
	logic [NW-1:0] kid1_mem [MAX_NODES];
	logic [AW-1:0] leaf_mem [MAX_NODES];
	logic [VW-1:0] val_mem  [MAX_ITEMS];

	logic [VW-1:0] x_q, mask_q, y_q, best_mask_q;
	logic          last_q, found_q;
	logic [NW-1:0] node_q, kid0_q, kid1_q;
	logic [NW:0]   used_q;
	logic [AW-1:0] leaf_q;
	logic [LW-1:0] lvl_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] lo_q, hi_q;
	logic [VW-1:0] best_score_q;
	logic          cleared_q;  // root cleared state pending
	logic          root_leaf_q;  // root leaf written in this set

	// effective level count, clamped
	logic [LW-1:0] levels;
	always_comb begin
		if ({{(32-KW){1'b0}}, key_bits} > MAX_KEY_BITS) levels = LW'(MAX_KEY_BITS);
		else levels = LW'(key_bits);
	end

	logic [BW-1:0] bit_idx;
	logic          b;
	logic [NW-1:0] kid_b, kid_nb;
	logic          root_blank;
	assign bit_idx   = BW'(lvl_q - 1'b1);
	assign b         = x_q[bit_idx];
	// the root reads as empty straight after a set restart
	assign root_blank = cleared_q && (node_q == '0);
	assign kid_b     = root_blank ? '0 : (b ? kid1_q : kid0_q);
	assign kid_nb    = root_blank ? '0 : (b ? kid0_q : kid1_q);

	assign sts.word_last   = last_of_set;
	assign sts.item_last   = last_q;
	assign sts.set_full    = !first_of_set && (count_q == CW'(MAX_ITEMS));
	assign sts.have_items  = !first_of_set && (count_q != '0);
	assign sts.levels_done = (lvl_q == '0);
	assign sts.s_stop      = (lvl_q == LW'(1)) || ((kid_b == '0) && (kid_nb == '0));
	assign sts.i_stop      = (kid_b == '0) && (used_q >= (NW+1)'(MAX_NODES));

	// node memory ports; the first write into a blank root clears the rest of it
	always_ff @(posedge clk) begin
		kid0_q <= kid0_mem[node_q];
		kid1_q <= kid1_mem[node_q];
		if (cmd.i_step && kid_b == '0 && !sts.i_stop) begin
			kid0_mem[used_q[NW-1:0]] <= '0;
			kid1_mem[used_q[NW-1:0]] <= '0;
			if (b) begin
				kid1_mem[node_q] <= used_q[NW-1:0];
				if (root_blank) kid0_mem[node_q] <= '0;
			end else begin
				kid0_mem[node_q] <= used_q[NW-1:0];
				if (root_blank) kid1_mem[node_q] <= '0;
			end
		end else if ((cmd.i_step || cmd.leaf_write) && root_blank) begin
			kid0_mem[node_q] <= '0;
			kid1_mem[node_q] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		leaf_q <= leaf_mem[node_q];
		if (cmd.i_step && kid_b == '0 && !sts.i_stop) leaf_mem[used_q[NW-1:0]] <= '0;
		else if (cmd.leaf_write) leaf_mem[node_q] <= count_q[AW-1:0];
		else if (root_blank && cmd.i_step) leaf_mem[node_q] <= '0;
	end

	// leaf of the reached node; an unwritten root leaf reads as item zero
	logic [AW-1:0] yi;
	logic [AW-1:0] yi_s;
	assign yi = (node_q == '0 && !root_leaf_q) ? '0 : leaf_q;

	// fetch the matched value once the leaf read has settled
	always_ff @(posedge clk) begin
		if (cmd.val_read) begin
			y_q  <= val_mem[yi];
			yi_s <= yi;
		end
		if (cmd.count_inc) val_mem[count_q[AW-1:0]] <= x_q;
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q    <= value;
			last_q <= last_of_set;
			mask_q <= '0;
			node_q <= '0;
			lvl_q  <= levels;
		end else if (cmd.s_step) begin
			if (kid_b != '0) begin
				if (!b) mask_q[bit_idx] <= 1'b1;
				node_q <= kid_b;
				lvl_q  <= lvl_q - 1'b1;
			end else if (kid_nb != '0) begin
				node_q <= kid_nb;
				lvl_q  <= lvl_q - 1'b1;
			end
		end else if (cmd.score) begin
			node_q <= '0;
			lvl_q  <= levels;
		end else if (cmd.i_step && !sts.i_stop) begin
			node_q <= (kid_b == '0) ? used_q[NW-1:0] : kid_b;
			lvl_q  <= lvl_q - 1'b1;
		end
	end

	// set bookkeeping and best pair
	logic [VW-1:0] score_v;
	logic [IW-1:0] j1, y1;
	assign score_v = (x_q ^ mask_q) & (y_q ^ mask_q);
	assign j1 = IW'(count_q) + 1'b1;
	assign y1 = IW'(yi_s) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q <= (NW+1)'(1);
			cleared_q <= 1'b1;
			root_leaf_q <= 1'b0;
			found_q <= 1'b0;
			best_score_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			best_mask_q <= '0;
		end else begin
			if (cmd.start && first_of_set) begin
				count_q <= '0;
				used_q <= (NW+1)'(1);
				cleared_q <= 1'b1;
				root_leaf_q <= 1'b0;
				found_q <= 1'b0;
				best_score_q <= '0;
				lo_q <= '0;
				hi_q <= '0;
				best_mask_q <= '0;
			end
			if (cmd.i_step) begin
				cleared_q <= 1'b0;
				if (kid_b == '0 && !sts.i_stop) used_q <= used_q + 1'b1;
			end
			if (cmd.leaf_write) begin
				cleared_q <= 1'b0;
				if (node_q == '0) root_leaf_q <= 1'b1;
			end
			if (cmd.count_inc) count_q <= count_q + 1'b1;
			if (cmd.score && (!found_q || score_v > best_score_q)) begin
				found_q <= 1'b1;
				best_score_q <= score_v;
				lo_q <= (y1 < j1) ? y1 : j1;
				hi_q <= (y1 < j1) ? j1 : y1;
				best_mask_q <= mask_q;
			end
		end
	end

	assign pair_found   = found_q;
	assign lower_index  = lo_q;
	assign higher_index = hi_q;
	assign best_mask    = best_mask_q;
endmodule

// File: hdl/min_xor_pair_trie_search_unit.sv
// Top level of the minimum-XOR pair trie search unit.
// Each word walks the trie twice, once to search and once to insert; on each
// walk every bit level issues the node read, waits for the registered data,
// then decides. The next word is taken only once both walks are done. The
// first word of a set, which has nothing to search, only inserts; a dead end
// in the search shortens the first walk, and a word past the set limit is
// taken without a walk. The node memory read is registered. The word marked
// last is followed by one result word held until taken.
module min_xor_pair_trie_search_unit #(
	parameter int MAX_ITEMS    = 1024,
	parameter int MAX_KEY_BITS = 30,
	parameter int MAX_NODES    = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [29:0] value,
	input  logic        first_of_set,
	input  logic        last_of_set,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pair_found,
	output logic [10:0] lower_index,
	output logic [10:0] higher_index,
	output logic [29:0] best_mask
);
	import mxp_pkg::*;

	mxp_cmd_t    cmd;
	mxp_status_t sts;
	logic [4:0]  key_bits_q;

	// hold the key width register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_bits_q <= 5'd30;
		else if (cfg_valid) key_bits_q <= cfg_data;
	end

	mxp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid), .sts(sts), .cmd(cmd)
	);

	mxp_dp #(
		.MAX_ITEMS(MAX_ITEMS), .MAX_KEY_BITS(MAX_KEY_BITS), .MAX_NODES(MAX_NODES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .key_bits(key_bits_q),
		.value(value), .first_of_set(first_of_set), .last_of_set(last_of_set),
		.pair_found(pair_found), .lower_index(lower_index),
		.higher_index(higher_index), .best_mask(best_mask)
	);
endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the minimum-XOR pair trie search unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITEMS   = 1024;
	localparam int N_LEVELS  = 30;
	localparam int N_NODES   = 32768;
	localparam int SETTLE    = 200;
	localparam int HOLD_OFF  = 3000;
	localparam longint LIMIT = 3000000;

	typedef struct {
		bit        found;
		bit [10:0] lo;
		bit [10:0] hi;
		bit [29:0] msk;
	} pair_res_t;

	typedef struct {
		bit [29:0] v;
		bit        first;
		bit        last;
		bit        has_exp;
		pair_res_t exp;
	} set_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [29:0] value;
	logic        first_of_set;
	logic        last_of_set;
	logic        out_valid;
	logic        out_stall;
	logic        pair_found;
	logic [10:0] lower_index;
	logic [10:0] higher_index;
	logic [29:0] best_mask;

	min_xor_pair_trie_search_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.first_of_set(first_of_set), .last_of_set(last_of_set),
		.out_valid(out_valid), .out_stall(out_stall), .pair_found(pair_found),
		.lower_index(lower_index), .higher_index(higher_index), .best_mask(best_mask)
	);

	// Trie model state
	int unsigned kid0 [N_NODES];
	int unsigned kid1 [N_NODES];
	int unsigned leaf_of [N_NODES];
	bit [29:0]   stored_vals [N_ITEMS];
	int unsigned nodes_used;
	int unsigned set_count;
	longint      best_score;
	bit [10:0]   best_lo;
	bit [10:0]   best_hi;
	bit [29:0]   best_msk;
	bit [4:0]    key_width;

	set_word_t   word_q [$];
	pair_res_t   pair_q [$];
	set_word_t   cur_word;
	bit          word_taken;
	bit          hold_req;
	int          errors;
	int          words_sent;
	int          pairs_seen;
	int          cfg_writes;
	longint      cycles;

	// Key widths picked most often in the random part
	bit [4:0]    kw_list [] = '{5'd1, 5'd2, 5'd5, 5'd8, 5'd13, 5'd17, 5'd24,
		5'd30, 5'd31, 5'd0, 5'd11};

	// Clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned trie_levels();
		return (key_width > N_LEVELS) ? N_LEVELS : key_width;
	endfunction

	function automatic void trie_clear();
		nodes_used = 1;
		kid0[0] = 0;
		kid1[0] = 0;
		leaf_of[0] = 0;
		set_count = 0;
		best_score = -1;
		best_lo = '0;
		best_hi = '0;
		best_msk = '0;
	endfunction

	// Walk towards the closest stored value and keep the pair if it scores better
	function automatic void trie_search(bit [29:0] x, int unsigned j);
		int unsigned node;
		bit [29:0]   msk;
		int unsigned yi;
		bit [29:0]   y;
		longint      score;
		bit          b;
		node = 0;
		msk = '0;
		for (int i = trie_levels(); i > 0; i--) begin
			b = x[i-1];
			if ((b ? kid1[node] : kid0[node]) != 0) begin
				if (!b)
					msk[i-1] = 1'b1;
				node = b ? kid1[node] : kid0[node];
			end else if ((b ? kid0[node] : kid1[node]) != 0) begin
				node = b ? kid0[node] : kid1[node];
			end else begin
				break;
			end
		end
		yi = leaf_of[node] % N_ITEMS;
		y = stored_vals[yi];
		score = longint'((x ^ msk) & (y ^ msk));
		if (score > best_score) begin
			best_score = score;
			best_lo = 11'((yi < j) ? yi + 1 : j + 1);
			best_hi = 11'((yi < j) ? j + 1 : yi + 1);
			best_msk = msk;
		end
	endfunction

	function automatic void trie_insert(bit [29:0] x, int unsigned j);
		int unsigned node;
		bit          b;
		node = 0;
		for (int i = trie_levels(); i > 0; i--) begin
			b = x[i-1];
			if ((b ? kid1[node] : kid0[node]) == 0) begin
				if (nodes_used >= N_NODES)
					return;
				kid0[nodes_used] = 0;
				kid1[nodes_used] = 0;
				leaf_of[nodes_used] = 0;
				if (b)
					kid1[node] = nodes_used;
				else
					kid0[node] = nodes_used;
				nodes_used++;
			end
			node = b ? kid1[node] : kid0[node];
		end
		leaf_of[node] = j;
	endfunction

	// Advance the model by one word; queue the pair when the set closes
	function automatic void predict_pair(set_word_t w);
		pair_res_t r;
		if (w.first)
			trie_clear();
		if (set_count < N_ITEMS) begin
			if (set_count > 0)
				trie_search(w.v, set_count);
			stored_vals[set_count] = w.v;
			trie_insert(w.v, set_count);
			set_count++;
		end
		if (!w.last)
			return;
		r = '{default: '0};
		if (best_score >= 0) begin
			r.found = 1'b1;
			r.lo = best_lo;
			r.hi = best_hi;
			r.msk = best_msk;
		end
		pair_q.push_back(w.has_exp ? w.exp : r);
	endfunction

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		pair_res_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycles);
			$display("tb_top failed");
			$finish;
		end else begin
			if (arst_n && in_valid && !in_stall) begin
				word_taken = 1'b1;
				words_sent++;
				predict_pair(cur_word);
			end
			if (arst_n && out_valid && !out_stall) begin
				pairs_seen++;
				if (pair_q.size() == 0) begin
					$display("%0t unexpected result word: found %0b lo %0d hi %0d mask %h",
						$time, pair_found, lower_index, higher_index, best_mask);
					errors++;
				end else begin
					e = pair_q.pop_front();
					if (pair_found !== e.found || lower_index !== e.lo ||
						higher_index !== e.hi || best_mask !== e.msk) begin
						$display("%0t mismatch: expected found %0b lo %0d hi %0d mask %h",
							$time, e.found, e.lo, e.hi, e.msk);
						$display("%0t           actual   found %0b lo %0d hi %0d mask %h",
							$time, pair_found, lower_index, higher_index, best_mask);
						errors++;
					end
				end
			end
		end
	end

	// Sender: bursts of words separated by random gaps
	initial begin
		int burst_left;
		int gap_left;
		in_valid = 1'b0;
		value = '0;
		first_of_set = 1'b0;
		last_of_set = 1'b0;
		burst_left = 4;
		gap_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (in_valid && !word_taken) begin
				// hold the stalled word
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (word_q.size() > 0) begin
				cur_word = word_q.pop_front();
				value <= cur_word.v;
				first_of_set <= cur_word.first;
				last_of_set <= cur_word.last;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
			word_taken = 1'b0;
		end
	end

	// Receiver: stall pattern of its own, plus one long hold-off
	initial begin
		int stall_pct;
		int span;
		int held;
		out_stall = 1'b0;
		stall_pct = 0;
		span = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_req && held < HOLD_OFF) begin
				held++;
				out_stall <= 1'b1;
			end else begin
				if (span == 0) begin
					span = $urandom_range(50, 250);
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 25;
						3: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				span--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic wait_idle();
		while (word_q.size() != 0 || in_valid || pair_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_key_width(bit [4:0] kw);
		@(negedge clk);
		cfg_data <= kw;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		key_width = kw;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_word(bit [29:0] v, bit f, bit l);
		set_word_t w;
		w = '{default: '0};
		w.v = v;
		w.first = f;
		w.last = l;
		word_q.push_back(w);
	endfunction

	function automatic void add_known(bit [29:0] v, bit f, bit l, bit fnd,
		int lo, int hi, bit [29:0] msk);
		set_word_t w;
		w.v = v;
		w.first = f;
		w.last = l;
		w.has_exp = 1'b1;
		w.exp.found = fnd;
		w.exp.lo = 11'(lo);
		w.exp.hi = 11'(hi);
		w.exp.msk = msk;
		word_q.push_back(w);
	endfunction

	// Pick a value: mostly within the key width, near the last one for shared prefixes
	function automatic bit [29:0] pick_value(bit [29:0] prev);
		bit [29:0] v;
		bit [29:0] kmask;
		int unsigned kw;
		kw = (key_width > N_LEVELS) ? N_LEVELS : key_width;
		kmask = (kw == 0) ? '0 : 30'h3FFFFFFF >> (N_LEVELS - kw);
		case ($urandom_range(0, 9))
			0, 1, 2: v = prev ^ (30'($urandom) & 30'h7);
			3, 4, 5, 6: v = 30'($urandom) & kmask;
			7: v = ($urandom_range(0, 1) != 0) ? kmask : '0;
			default: v = 30'($urandom);
		endcase
		return v;
	endfunction

	typedef struct {
		bit [29:0] v;
		bit        f;
		bit        l;
		bit        known;
		bit        fnd;
		int        lo;
		int        hi;
		bit [29:0] msk;
	} stim_row_t;

	// Directed words at the reset key width of 30
	stim_row_t stim_rows [] = '{
		'{30'h0000007, 1, 1, 1, 0, 0, 0, 30'h0},
		'{30'h0000005, 1, 0, 0, 0, 0, 0, 30'h0},
		'{30'h0000005, 0, 1, 1, 1, 1, 2, 30'h3FFFFFFA},
		'{30'h0000000, 1, 0, 0, 0, 0, 0, 30'h0},
		'{30'h3FFFFFFF, 0, 1, 1, 1, 1, 2, 30'h0},
		'{30'h3FFFFFFF, 1, 0, 0, 0, 0, 0, 30'h0},
		'{30'h0000000, 0, 0, 0, 0, 0, 0, 30'h0},
		'{30'h0000001, 0, 0, 0, 0, 0, 0, 30'h0},
		'{30'h2AAAAAAA, 0, 0, 0, 0, 0, 0, 30'h0},
		'{30'h15555555, 0, 0, 0, 0, 0, 0, 30'h0},
		'{30'h2AAAAAAB, 0, 1, 0, 0, 0, 0, 30'h0},
		'{30'h0000100, 0, 1, 0, 0, 0, 0, 30'h0}
	};

	initial begin
		bit [29:0] prev;
		int        n;
		int        rnd_words;
		errors = 0;
		cycles = 0;
		hold_req = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		key_width = 5'd30;
		trie_clear();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at reset settings
		foreach (stim_rows[i]) begin
			if (stim_rows[i].known)
				add_known(stim_rows[i].v, stim_rows[i].f, stim_rows[i].l,
					stim_rows[i].fnd, stim_rows[i].lo, stim_rows[i].hi, stim_rows[i].msk);
			else
				add_word(stim_rows[i].v, stim_rows[i].f, stim_rows[i].l);
		end
		wait_idle();

		// No trie levels: everything stops at the root
		write_key_width(5'd0);
		add_word(30'h12345678, 1, 0);
		add_word(30'h0FEDCBA9, 0, 0);
		add_word(30'h3FFFFFFF, 0, 1);
		wait_idle();

		// Widest setting above the limit, then a narrow one with wide values
		write_key_width(5'd31);
		add_word(30'h3FFF0000, 1, 0);
		add_word(30'h3FFF0001, 0, 1);
		wait_idle();
		write_key_width(5'd1);
		add_word(30'h3FFFFFFE, 1, 0);
		add_word(30'h00000001, 0, 0);
		add_word(30'h20000000, 0, 1);
		wait_idle();

		// Change width mid-set without a first mark: dead ends in the walk
		write_key_width(5'd4);
		add_word(30'h3, 1, 0);
		add_word(30'hC, 0, 1);
		wait_idle();
		write_key_width(5'd8);
		add_word(30'hF3, 0, 0);
		add_word(30'h03, 0, 1);
		wait_idle();

		// Oversized set at a small width: words past the limit are dropped
		write_key_width(5'd3);
		prev = '0;
		for (int i = 0; i < N_ITEMS + 6; i++) begin
			prev = pick_value(prev);
			add_word(prev, i == 0, i == N_ITEMS || i == N_ITEMS + 5);
		end
		wait_idle();

		// Random sets across several widths; long receiver hold-off early on
		rnd_words = 0;
		hold_req = 1'b1;
		while (rnd_words < 800) begin
			write_key_width(($urandom_range(0, 3) == 0) ? 5'($urandom) :
				kw_list[$urandom_range(0, kw_list.size() - 1)]);
			for (int s = 0; s < 8; s++) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
				prev = 30'($urandom);
				for (int i = 0; i < n; i++) begin
					prev = pick_value(prev);
					if ($urandom_range(0, 9) == 0)
						add_word(prev, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
					else
						add_word(prev, i == 0, i == n - 1);
				end
				rnd_words += n;
			end
			wait_idle();
		end

		$display("Run covered %0d words and %0d result words over %0d key width settings,",
			words_sent, pairs_seen, cfg_writes);
		$display("including no-level walks, dead ends, an oversized set and a long output hold-off.");
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

// File: filelist.f
hdl/mxp_pkg.sv
hdl/mxp_ctrl.sv
hdl/mxp_dp.sv
hdl/min_xor_pair_trie_search_unit.sv
dv/tb_top.sv
